[src/rigid_frame_accumulator_top_assert.svh]
// Assertion macros for the rigid frame accumulator top level.
// Included by rigid_frame_accumulator_top; expects clk and rst_n in scope.
`ifndef RIGID_FRAME_ACCUMULATOR_TOP_ASSERT_SVH
`define RIGID_FRAME_ACCUMULATOR_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is active
`define RFA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is active
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rfa_pkg.sv]
// Shared types, constants and helpers for the rigid frame accumulator.
// No dependencies; used by the top level, rfa_mulu and rfa_rootdiv.
`default_nettype none

package rfa_pkg;

    localparam int POS_W  = 32;
    localparam int QUAT_W = 32;
    localparam int QFRAC  = 30;

    localparam logic [63:0] NORM_FLOOR = 64'd11529;

    // negated terms of the quaternion product, bit index {part, term}
    localparam logic [15:0] QMUL_NEG_MASK = 16'h428E;

    typedef enum logic [1:0] {
        CMD_ACC  = 2'd0,
        CMD_UNDO = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_NOP  = 2'd3
    } rfa_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QMUL,
        ST_NSCALE,
        ST_NSQ,
        ST_NCHK,
        ST_NSQRT,
        ST_NDIVLD,
        ST_NDIV,
        ST_NSTORE,
        ST_RPROD,
        ST_RMAT,
        ST_RAPPLY,
        ST_DONE
    } rfa_state_t;

    typedef struct packed {
        logic        sqrt_start;
        logic        div_start;
        logic [63:0] operand;
        logic [31:0] divisor;
    } rfa_rd_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } rfa_rd_rsp_t;

    // operand pair of each rotation-matrix product: {a, b} orientation indices
    function automatic logic [3:0] rot_pair(input logic [3:0] idx);
        logic [3:0] p;
        unique case (idx)
            4'd1:    p = {2'd1, 2'd1};
            4'd2:    p = {2'd2, 2'd2};
            4'd3:    p = {2'd3, 2'd3};
            4'd4:    p = {2'd1, 2'd2};
            4'd5:    p = {2'd0, 2'd3};
            4'd6:    p = {2'd1, 2'd3};
            4'd7:    p = {2'd0, 2'd2};
            4'd8:    p = {2'd2, 2'd3};
            4'd9:    p = {2'd0, 2'd1};
            default: p = {2'd0, 2'd0};
        endcase
        return p;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] y;
        if (x > 40'sd2147483647)
            y = 32'sh7FFF_FFFF;
        else if (x < -40'sd2147483648)
            y = 32'sh8000_0000;
        else
            y = x[31:0];
        return y;
    endfunction

endpackage

`default_nettype wire

[src/rfa_if.sv]
// Valid/ready channel interfaces for the step input and the frame result.
// Depends on nothing; payload field names follow the block's item layout.
`default_nettype none

interface rfa_step_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] step_pos_x;
    logic signed [31:0] step_pos_y;
    logic signed [31:0] step_pos_z;
    logic signed [31:0] step_quat_w;
    logic signed [31:0] step_quat_x;
    logic signed [31:0] step_quat_y;
    logic signed [31:0] step_quat_z;

    modport source (
        output valid, cmd, step_pos_x, step_pos_y, step_pos_z,
               step_quat_w, step_quat_x, step_quat_y, step_quat_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, step_pos_x, step_pos_y, step_pos_z,
               step_quat_w, step_quat_x, step_quat_y, step_quat_z,
        output ready
    );
endinterface

interface rfa_frame_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] frame_pos_x;
    logic signed [31:0] frame_pos_y;
    logic signed [31:0] frame_pos_z;
    logic signed [31:0] frame_quat_w;
    logic signed [31:0] frame_quat_x;
    logic signed [31:0] frame_quat_y;
    logic signed [31:0] frame_quat_z;
    logic               norm_skipped;

    modport source (
        output valid, frame_pos_x, frame_pos_y, frame_pos_z, frame_quat_w,
               frame_quat_x, frame_quat_y, frame_quat_z, norm_skipped,
        input  ready
    );
    modport sink (
        input  valid, frame_pos_x, frame_pos_y, frame_pos_z, frame_quat_w,
               frame_quat_x, frame_quat_y, frame_quat_z, norm_skipped,
        output ready
    );
endinterface

`default_nettype wire

[src/rigid_frame_accumulator_top.sv]
// Top level of the rigid frame accumulator: sequencer, frame state, datapath.
// Depends on rfa_pkg, rfa_if, rfa_mulu, rfa_rootdiv and the assertion header.
//
//  channel | modport | beat carries
//  --------+---------+---------------------------------------------------
//  step    | sink    | cmd, step offset (Q16.16), step rotation (Q2.30)
//  frame   | source  | updated position, orientation, norm_skipped flag
//
// Accumulate and undo run the full sequence; load and no-op go straight to done.
// The work is set by the one shared multiplier (16 + 4 + 10 + 9 products)
// and the bit-serial root/divide unit (a root, then four divides); a
// skipped normalisation drops the root and the divides.
// Reset puts the frame at the origin with the identity orientation.
// step.ready is high only while the sequencer is idle; a result waiting
// on frame does not block the next step beat until that beat is finished.
`default_nettype none

module rigid_frame_accumulator_top
    import rfa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rfa_step_if.sink    step,
    rfa_frame_if.source frame
);

    rfa_state_t state_reg, state_next;

    logic [1:0]         cmd_reg;
    logic [3:0]         cnt_reg;
    logic               mph_reg;
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic               skip_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] ori_reg [4];
    logic signed [31:0] sp_reg  [3];
    logic signed [32:0] sq_reg  [4];
    logic signed [35:0] r_reg   [4];
    logic signed [35:0] pp_reg  [10];
    logic signed [31:0] m_reg   [3][3];
    logic signed [37:0] acc_reg;
    logic        [63:0] n2_reg;
    logic        [31:0] nrm_reg;

    logic               ovalid_reg;
    logic signed [31:0] opos_reg [3];
    logic signed [31:0] oori_reg [4];
    logic               oskip_reg;

    logic               take;
    logic               out_free;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    logic signed [35:0] mul_rnd;

    rfa_rd_req_t        rd_req;
    rfa_rd_rsp_t        rd_rsp;

    logic [3:0]         pair;
    logic signed [37:0] qterm;
    logic signed [37:0] qsum;
    logic signed [37:0] vsum;
    logic               big;
    logic signed [35:0] rsel;
    logic signed [35:0] rmag;
    logic [61:0]        num;
    logic signed [35:0] dq;

    rfa_mulu u_mulu (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod),
        .rnd  (mul_rnd)
    );

    rfa_rootdiv u_rootdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rd_req),
        .rsp   (rd_rsp)
    );

    assign take     = step.valid && step.ready;
    assign out_free = !ovalid_reg || frame.ready;

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (rfa_cmd_t'(step.cmd))
                        CMD_ACC:  state_next = ST_RPROD;
                        CMD_UNDO: state_next = ST_QMUL;
                        CMD_LOAD: state_next = ST_DONE;
                        CMD_NOP:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_QMUL:
                if (mph_reg && cnt_reg == 4'd15)
                    state_next = ST_NSCALE;
            ST_NSCALE:
                state_next = ST_NSQ;
            ST_NSQ:
                if (mph_reg && cnt_reg == 4'd3)
                    state_next = ST_NCHK;
            ST_NCHK:
                state_next = (n2_reg < NORM_FLOOR) ? ST_NSTORE : ST_NSQRT;
            ST_NSQRT:
                if (rd_rsp.done)
                    state_next = ST_NDIVLD;
            ST_NDIVLD:
                state_next = ST_NDIV;
            ST_NDIV:
                if (rd_rsp.done)
                    state_next = (cnt_reg[1:0] == 2'd3) ? ST_NSTORE : ST_NDIVLD;
            ST_NSTORE:
                state_next = (rfa_cmd_t'(cmd_reg) == CMD_ACC) ? ST_DONE : ST_RPROD;
            ST_RPROD:
                if (mph_reg && cnt_reg == 4'd9)
                    state_next = ST_RMAT;
            ST_RMAT:
                state_next = ST_RAPPLY;
            ST_RAPPLY:
                if (mph_reg && row_reg == 2'd2 && col_reg == 2'd2)
                    state_next = (rfa_cmd_t'(cmd_reg) == CMD_ACC) ? ST_QMUL : ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer: handshake, multiplier operands, root/divide
    always_comb
    begin
        step.ready = (state_reg == ST_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        pair       = rot_pair(cnt_reg);
        rsel       = r_reg[cnt_reg[1:0]];
        rmag       = rsel[35] ? -rsel : rsel;
        num        = {rmag[31:0], 30'd0} + {31'd0, nrm_reg[31:1]};
        rd_req     = '0;

        unique case (state_reg)
            ST_QMUL:
            begin
                mul_a = {ori_reg[cnt_reg[1:0]][31], ori_reg[cnt_reg[1:0]]};
                mul_b = sq_reg[cnt_reg[3:2] ^ cnt_reg[1:0]];
            end
            ST_NSQ:
            begin
                mul_a = r_reg[cnt_reg[1:0]][32:0];
                mul_b = r_reg[cnt_reg[1:0]][32:0];
            end
            ST_RPROD:
            begin
                mul_a = {ori_reg[pair[3:2]][31], ori_reg[pair[3:2]]};
                mul_b = {ori_reg[pair[1:0]][31], ori_reg[pair[1:0]]};
            end
            ST_RAPPLY:
            begin
                mul_a = {m_reg[row_reg][col_reg][31], m_reg[row_reg][col_reg]};
                mul_b = {sp_reg[col_reg][31], sp_reg[col_reg]};
            end
            ST_NCHK:
            begin
                rd_req.sqrt_start = (n2_reg >= NORM_FLOOR);
                rd_req.operand    = n2_reg;
            end
            ST_NDIVLD:
            begin
                rd_req.div_start = 1'b1;
                rd_req.operand   = {2'b00, num};
                rd_req.divisor   = nrm_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath helpers
    assign qterm = QMUL_NEG_MASK[cnt_reg] ? -38'(mul_rnd) : 38'(mul_rnd);
    assign qsum  = acc_reg + qterm;
    assign vsum  = acc_reg + 38'(mul_rnd);
    assign dq    = rsel[35] ? -36'(signed'({1'b0, rd_rsp.result}))
                            :  36'(signed'({1'b0, rd_rsp.result}));

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 4; i++)
            if (r_reg[i] >= 36'sd2147483648 || r_reg[i] <= -36'sd2147483648)
                big = 1'b1;
    end

    // ------------------------------------------------------------------
    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= '0;
            cnt_reg    <= '0;
            mph_reg    <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            skip_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= '0;
            ori_reg[0] <= 32'sh4000_0000;
            ori_reg[1] <= '0;
            ori_reg[2] <= '0;
            ori_reg[3] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (frame.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_DONE && out_free)
                ovalid_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg  <= '0;
                    mph_reg  <= 1'b0;
                    row_reg  <= '0;
                    col_reg  <= '0;
                    skip_reg <= 1'b0;
                    if (take)
                    begin
                        cmd_reg <= step.cmd;
                        if (rfa_cmd_t'(step.cmd) == CMD_LOAD)
                        begin
                            pos_reg[0] <= step.step_pos_x;
                            pos_reg[1] <= step.step_pos_y;
                            pos_reg[2] <= step.step_pos_z;
                            ori_reg[0] <= step.step_quat_w;
                            ori_reg[1] <= step.step_quat_x;
                            ori_reg[2] <= step.step_quat_y;
                            ori_reg[3] <= step.step_quat_z;
                        end
                    end
                end
                ST_QMUL, ST_NSQ, ST_RPROD:
                begin
                    mph_reg <= !mph_reg;
                    if (mph_reg)
                        cnt_reg <= (state_next == state_reg) ? cnt_reg + 4'd1 : 4'd0;
                end
                ST_NCHK:
                begin
                    cnt_reg <= '0;
                    if (n2_reg < NORM_FLOOR)
                        skip_reg <= 1'b1;
                end
                ST_NDIV:
                    if (rd_rsp.done)
                        cnt_reg <= cnt_reg + 4'd1;
                ST_NSTORE:
                begin
                    cnt_reg <= '0;
                    mph_reg <= 1'b0;
                    for (int i = 0; i < 4; i++)
                        ori_reg[i] <= sat32(40'(r_reg[i]));
                end
                ST_RMAT:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    mph_reg <= 1'b0;
                end
                ST_RAPPLY:
                begin
                    mph_reg <= !mph_reg;
                    if (mph_reg)
                    begin
                        if (col_reg == 2'd2)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                            // offset row finished: fold into position
                            if (rfa_cmd_t'(cmd_reg) == CMD_ACC)
                                pos_reg[row_reg] <= sat32(40'(pos_reg[row_reg]) + 40'(vsum));
                            else
                                pos_reg[row_reg] <= sat32(40'(pos_reg[row_reg]) - 40'(vsum));
                        end
                        else
                            col_reg <= col_reg + 2'd1;
                        if (state_next != state_reg)
                            cnt_reg <= '0;
                    end
                end
                default:
                begin
                    mph_reg <= mph_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // working registers (no reset)
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    sp_reg[0] <= step.step_pos_x;
                    sp_reg[1] <= step.step_pos_y;
                    sp_reg[2] <= step.step_pos_z;
                    sq_reg[0] <= 33'(step.step_quat_w);
                    // undo composes with the conjugate of the step rotation
                    if (rfa_cmd_t'(step.cmd) == CMD_UNDO)
                    begin
                        sq_reg[1] <= -33'(step.step_quat_x);
                        sq_reg[2] <= -33'(step.step_quat_y);
                        sq_reg[3] <= -33'(step.step_quat_z);
                    end
                    else
                    begin
                        sq_reg[1] <= 33'(step.step_quat_x);
                        sq_reg[2] <= 33'(step.step_quat_y);
                        sq_reg[3] <= 33'(step.step_quat_z);
                    end
                end
            end
            ST_QMUL:
            begin
                if (mph_reg)
                begin
                    acc_reg <= (cnt_reg[1:0] == 2'd0) ? qterm : qsum;
                    if (cnt_reg[1:0] == 2'd3)
                        r_reg[cnt_reg[3:2]] <= qsum[35:0];
                end
            end
            ST_NSCALE:
            begin
                n2_reg <= '0;
                // oversized parts: drop four bits, rounded, direction kept
                if (big)
                    for (int i = 0; i < 4; i++)
                        r_reg[i] <= (r_reg[i] + 36'sd8) >>> 4;
            end
            ST_NSQ:
                if (mph_reg)
                    n2_reg <= n2_reg + mul_prod[63:0];
            ST_NSQRT:
                if (rd_rsp.done)
                    nrm_reg <= rd_rsp.result;
            ST_NDIV:
                if (rd_rsp.done)
                    r_reg[cnt_reg[1:0]] <= dq;
            ST_RPROD:
                if (mph_reg)
                    pp_reg[cnt_reg] <= mul_rnd;
            ST_RMAT:
            begin
                m_reg[0][0] <= sat32(40'(pp_reg[0]) + 40'(pp_reg[1]) - 40'(pp_reg[2])
                                     - 40'(pp_reg[3]));
                m_reg[1][1] <= sat32(40'(pp_reg[0]) - 40'(pp_reg[1]) + 40'(pp_reg[2])
                                     - 40'(pp_reg[3]));
                m_reg[2][2] <= sat32(40'(pp_reg[0]) - 40'(pp_reg[1]) - 40'(pp_reg[2])
                                     + 40'(pp_reg[3]));
                m_reg[0][1] <= sat32((40'(pp_reg[4]) - 40'(pp_reg[5])) <<< 1);
                m_reg[0][2] <= sat32((40'(pp_reg[6]) + 40'(pp_reg[7])) <<< 1);
                m_reg[1][0] <= sat32((40'(pp_reg[4]) + 40'(pp_reg[5])) <<< 1);
                m_reg[1][2] <= sat32((40'(pp_reg[8]) - 40'(pp_reg[9])) <<< 1);
                m_reg[2][0] <= sat32((40'(pp_reg[6]) - 40'(pp_reg[7])) <<< 1);
                m_reg[2][1] <= sat32((40'(pp_reg[8]) + 40'(pp_reg[9])) <<< 1);
            end
            ST_RAPPLY:
                if (mph_reg)
                    acc_reg <= (col_reg == 2'd0) ? 38'(mul_rnd) : vsum;
            ST_DONE:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < 3; i++)
                        opos_reg[i] <= pos_reg[i];
                    for (int i = 0; i < 4; i++)
                        oori_reg[i] <= ori_reg[i];
                    oskip_reg <= skip_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign frame.valid        = ovalid_reg;
    assign frame.frame_pos_x  = opos_reg[0];
    assign frame.frame_pos_y  = opos_reg[1];
    assign frame.frame_pos_z  = opos_reg[2];
    assign frame.frame_quat_w = oori_reg[0];
    assign frame.frame_quat_x = oori_reg[1];
    assign frame.frame_quat_y = oori_reg[2];
    assign frame.frame_quat_z = oori_reg[3];
    assign frame.norm_skipped = oskip_reg;

    // ------------------------------------------------------------------
    // checks
`include "rigid_frame_accumulator_top_assert.svh"

    `RFA_ASSERT_IMPLY(a_rd_busy_phase, rd_rsp.busy,
        (state_reg == ST_NSQRT || state_reg == ST_NDIV), "root/divide busy outside its phase")
    `RFA_ASSERT_IMPLY(a_skip_floor, (skip_reg && state_reg == ST_NSTORE),
        (n2_reg < NORM_FLOOR), "norm skipped above the floor")
    `RFA_ASSERT_NEXT(a_done_holds, (state_reg == ST_DONE && ovalid_reg && !frame.ready),
        (state_reg == ST_DONE), "finished beat overwrote a waiting result")

endmodule

`default_nettype wire

[src/rfa_mulu.sv]
// Shared signed multiplier: registered 33x33 product plus Q.30 rounding.
// Depends on rfa_pkg.
`default_nettype none

module rfa_mulu
    import rfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [32:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [65:0]      prod,
    output logic signed [35:0]      rnd
);

    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;
    logic signed [65:0] biased;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // round half up, then floor shift by the fraction width
    assign biased = prod_reg + (66'sd1 <<< (QFRAC - 1));
    assign rnd    = biased[65:QFRAC];
    assign prod   = prod_reg;

endmodule

`default_nettype wire

[src/rfa_rootdiv.sv]
// Iterative floor square root (64 -> 32 bits) and 62/32 restoring divide.
// One result bit per cycle in either mode. Depends on rfa_pkg.
`default_nettype none

module rfa_rootdiv
    import rfa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire rfa_rd_req_t req,
    output rfa_rd_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sqrt_mode_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] sh_reg;
    logic [35:0] rem_reg;
    logic [31:0] acc_reg;
    logic [31:0] div_reg;

    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;

    always_comb
    begin
        if (sqrt_mode_reg)
        begin
            rem2  = {rem_reg[33:0], sh_reg[63:62]};
            trial = {2'b00, acc_reg, 2'b01};
        end
        else
        begin
            rem2  = {rem_reg[34:0], sh_reg[63]};
            trial = {4'b0000, div_reg};
        end
        ge = (rem2 >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.sqrt_start || req.div_start)
            busy_next = 1'b1;
        else if (busy_reg && cnt_reg == 6'd1)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (req.sqrt_start || req.div_start)
                cnt_reg <= 6'd32;
            else if (busy_reg)
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.sqrt_start)
        begin
            sqrt_mode_reg <= 1'b1;
            sh_reg        <= req.operand;
            rem_reg       <= '0;
            acc_reg       <= '0;
        end
        else if (req.div_start)
        begin
            sqrt_mode_reg <= 1'b0;
            sh_reg        <= {req.operand[31:0], 32'd0};
            rem_reg       <= {6'd0, req.operand[61:32]};
            acc_reg       <= '0;
            div_reg       <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem2 - trial) : rem2;
            acc_reg <= {acc_reg[30:0], ge};
            sh_reg  <= sqrt_mode_reg ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], 1'b0};
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

`default_nettype wire
